FILE: hdl/tlv_hex_tag_parser_unit_macros.svh
// assertion macros for the tlv hex tag parser
// used by tlvhp_parse and tlvhp_outq, needs clk and rst_n in scope
`ifndef TLV_HEX_TAG_PARSER_UNIT_MACROS_SVH
`define TLV_HEX_TAG_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define TLVHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TLVHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tlvhp_pkg.sv
// shared types and constants for the tlv hex tag parser
// no dependencies
package tlvhp_pkg;

  localparam int unsigned MAX_LEN_DEF     = 65535;
  localparam int unsigned OFFSET_BITS_DEF = 24;
  localparam int unsigned TAG_OFF_W       = 24;
  localparam int unsigned OUT_DATA_W      = 72;
  localparam int unsigned IN_DATA_W       = 8;
  localparam int unsigned CFG_AW          = 3;
  localparam int unsigned Q_DEPTH         = 4;
  localparam int unsigned Q_PTR_W         = 2;
  localparam int unsigned Q_CNT_W         = 3;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_VAL = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;
  localparam logic [1:0] KIND_ERR = 2'd3;

  localparam logic ERR_SHORT = 1'b0;
  localparam logic ERR_LEN   = 1'b1;

  localparam logic [0:0] REG_MASK_CTOR = 1'b0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [1:0]           kind;
    logic [15:0]          tag_value;
    logic                 ctor_flag;
    logic                 space_form;
    logic [15:0]          value_len;
    logic [TAG_OFF_W-1:0] tag_offset;
    logic [7:0]           value_byte;
    logic                 value_last;
    logic                 error_code;
    logic                 run_last;
  } rec_t;

endpackage

FILE: hdl/tlvhp_parse.sv
// parser state and per-item decode, produces up to two records per item
// depends on tlvhp_pkg and tlv_hex_tag_parser_unit_macros.svh
`include "tlv_hex_tag_parser_unit_macros.svh"

module tlvhp_parse #(
  parameter int unsigned MAX_LEN     = tlvhp_pkg::MAX_LEN_DEF,
  parameter int unsigned OFFSET_BITS = tlvhp_pkg::OFFSET_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              eom,
  input  logic              mask_ctor,
  output tlvhp_pkg::rec_t   rec0,
  output tlvhp_pkg::rec_t   rec1,
  output logic [1:0]        rec_cnt
);
  import tlvhp_pkg::*;

  localparam logic [2:0] PH_TAG    = 3'd0;
  localparam logic [2:0] PH_LEN0   = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_DROP   = 3'd4;

  logic [2:0]             phase_r, phase_nxt;
  logic [1:0]             hex_r, hex_nxt;
  logic [15:0]            tag_r, tag_nxt;
  logic [15:0]            len_r, len_nxt;
  logic                   neg_r, neg_nxt;
  logic                   seen_r, seen_nxt;
  logic                   over_r, over_nxt;
  logic [15:0]            rem_r, rem_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;

  logic [15:0] hex_d;
  logic        is_digit;
  logic [19:0] len_v;
  logic [15:0] rem_dec;
  rec_t        hdr;
  rec_t        e0;
  logic        e0_v, end_v, len_byte;

  assign hex_d    = {8'h00, data_byte} - ((data_byte > CH_NINE) ? 16'h0037 : 16'h0030);
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign len_v    = {1'b0, len_r, 3'b000} + {3'b000, len_r, 1'b0}
                  + {16'h0000, data_byte[3:0]};
  assign rem_dec  = rem_r - 16'd1;

  always_comb begin
    hdr              = '0;
    hdr.kind         = KIND_HDR;
    hdr.tag_value    = mask_ctor ? {1'b0, tag_r[14:0]} : tag_r;
    hdr.ctor_flag    = tag_r[15];
    hdr.value_len    = len_r;
    hdr.tag_offset   = TAG_OFF_W'(start_r);
  end

  always_comb begin
    phase_nxt = phase_r;
    hex_nxt   = hex_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    over_nxt  = over_r;
    rem_nxt   = rem_r;
    off_nxt   = off_r + 1'b1;
    start_nxt = start_r;
    e0        = '0;
    e0_v      = 1'b0;
    end_v     = 1'b0;
    len_byte  = 1'b0;

    case (phase_r)
      PH_TAG: begin
        if (hex_r == 2'd0) start_nxt = off_r;
        tag_nxt = {tag_r[11:0], 4'h0} + hex_d;
        if (hex_r == 2'd3) begin
          hex_nxt   = 2'd0;
          phase_nxt = PH_LEN0;
        end else begin
          hex_nxt = hex_r + 2'd1;
        end
        if (eom) begin
          e0_v = 1'b1; e0.kind = KIND_ERR; e0.error_code = ERR_SHORT;
          phase_nxt = PH_DROP;
        end
      end
      PH_LEN0: begin
        if (data_byte == CH_SPACE) begin
          e0_v = 1'b1;
          e0 = hdr;
          e0.space_form = 1'b1;
          e0.value_len = '0;
          end_v = eom;
          phase_nxt = PH_TAG;
        end else begin
          phase_nxt = PH_DIGITS;
          if (data_byte == CH_MINUS) begin
            neg_nxt = 1'b1;
            if (eom) begin
              e0_v = 1'b1; e0.kind = KIND_ERR; e0.error_code = ERR_LEN;
              phase_nxt = PH_DROP;
            end
          end else begin
            len_byte = 1'b1;
          end
        end
      end
      PH_DIGITS: len_byte = 1'b1;
      PH_VALUE: begin
        rem_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          e0_v = 1'b1; e0.kind = KIND_VAL; e0.value_byte = data_byte; e0.value_last = 1'b1;
          end_v = eom;
          phase_nxt = PH_TAG;
        end else if (eom) begin
          e0_v = 1'b1; e0.kind = KIND_ERR; e0.error_code = ERR_SHORT;
          phase_nxt = PH_DROP;
        end else begin
          e0_v = 1'b1; e0.kind = KIND_VAL; e0.value_byte = data_byte;
        end
      end
      default: ;
    endcase

    if (len_byte) begin
      if (is_digit) begin
        seen_nxt = 1'b1;
        if (!over_r) begin
          if (len_v > 20'(MAX_LEN)) over_nxt = 1'b1;
          else len_nxt = len_v[15:0];
        end
        if (eom) begin
          e0_v = 1'b1; e0.kind = KIND_ERR;
          e0.error_code = (!neg_r && over_nxt) ? ERR_LEN : ERR_SHORT;
          phase_nxt = PH_DROP;
        end
      end else if (!seen_r || (!neg_r && over_r)) begin
        e0_v = 1'b1; e0.kind = KIND_ERR; e0.error_code = ERR_LEN;
        phase_nxt = PH_DROP;
      end else if (neg_r && (len_r != 16'd0 || over_r)) begin
        e0_v = 1'b1; e0.kind = KIND_ERR; e0.error_code = ERR_SHORT;
        phase_nxt = PH_DROP;
      end else if (len_r == 16'd0) begin
        e0_v = 1'b1; e0 = hdr;
        end_v = eom;
        phase_nxt = PH_TAG;
      end else if (eom) begin
        e0_v = 1'b1; e0.kind = KIND_ERR; e0.error_code = ERR_SHORT;
        phase_nxt = PH_DROP;
      end else begin
        e0_v = 1'b1; e0 = hdr;
        rem_nxt = len_r;
        phase_nxt = PH_VALUE;
      end
    end

    // back at a tag boundary, or message end: parse fields start over
    if ((phase_nxt == PH_TAG && phase_r != PH_TAG) || eom) begin
      phase_nxt = PH_TAG;
      hex_nxt   = '0;
      tag_nxt   = '0;
      len_nxt   = '0;
      neg_nxt   = 1'b0;
      seen_nxt  = 1'b0;
      over_nxt  = 1'b0;
      rem_nxt   = '0;
    end
    if (eom) begin
      off_nxt   = '0;
      start_nxt = '0;
    end
  end

  always_comb begin
    rec0          = e0;
    rec1          = '0;
    rec1.kind     = KIND_END;
    rec1.run_last = 1'b1;
    rec0.run_last = !end_v;
    rec_cnt       = {1'b0, e0_v} + {1'b0, end_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      hex_r   <= '0;
      tag_r   <= '0;
      len_r   <= '0;
      neg_r   <= 1'b0;
      seen_r  <= 1'b0;
      over_r  <= 1'b0;
      rem_r   <= '0;
      off_r   <= '0;
      start_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hex_r   <= hex_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      neg_r   <= neg_nxt;
      seen_r  <= seen_nxt;
      over_r  <= over_nxt;
      rem_r   <= rem_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
    end
  end

  `TLVHP_ASSERT_NXT(a_eom_restart, step && eom, phase_r == PH_TAG && off_r == '0, "state not cleared after message end")
  `TLVHP_ASSERT_NOW(a_second_is_end, rec_cnt == 2'd2, e0_v && end_v, "two records without end record")
  `TLVHP_ASSERT_NOW(a_value_has_rem, phase_r == PH_VALUE, rem_r != 16'd0, "value phase with nothing left")
  `TLVHP_ASSERT_NOW(a_drop_silent, phase_r == PH_DROP, rec_cnt == 2'd0, "record made while dropping")

endmodule

FILE: hdl/tlvhp_outq.sv
// small result queue, takes up to two records per cycle while room is high, gives one while out_ready is high
// depends on tlvhp_pkg and tlv_hex_tag_parser_unit_macros.svh
`include "tlv_hex_tag_parser_unit_macros.svh"

module tlvhp_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      push_cnt,
  input  tlvhp_pkg::rec_t rec0,
  input  tlvhp_pkg::rec_t rec1,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output tlvhp_pkg::rec_t out_rec
);
  import tlvhp_pkg::*;

  rec_t                 mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_r, wr_nxt;
  logic [Q_PTR_W-1:0]   rd_r, rd_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [Q_PTR_W-1:0]   wr_p1;
  logic                 pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != '0;
  assign out_rec   = mem[rd_r];
  assign room      = cnt_r <= Q_CNT_W'(Q_DEPTH - 2);
  assign wr_p1     = wr_r + 1'b1;
  assign wr_nxt    = wr_r + Q_PTR_W'(push_cnt);
  assign rd_nxt    = rd_r + Q_PTR_W'(pop);
  assign cnt_nxt   = cnt_r + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_r] <= rec0;
    if (push_cnt == 2'd2) mem[wr_p1] <= rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `TLVHP_ASSERT_NOW(a_push_room, push_cnt != 2'd0, room, "push without room")
  `TLVHP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= Q_CNT_W'(Q_DEPTH), "queue count overflow")
  `TLVHP_ASSERT_NOW(a_ptr_track, 1'b1, Q_PTR_W'(rd_r + cnt_r[Q_PTR_W-1:0]) == wr_r, "queue pointers out of step")

endmodule

FILE: hdl/tlv_hex_tag_parser_unit.sv
// channel       | dir | handshake                 | payload
// in_  stream   | in  | in_tvalid / in_tready     | tdata data_byte, tlast end_of_message
// out_ stream   | out | out_tvalid / out_tready   | tuser kind, tdata record, tlast run_last
// apb config    | in  | psel penable pwrite pready| paddr[2] register, pwdata[0] mask_ctor
// one item per cycle sustained while the queue has room: input register, decode, then a 4-entry queue
// an item can make two records; with out_tready high the queue never backs up
// first record shows on out_ after the input register and the queue, taken at an edge with out_tready high
// rst_n synchronous; in_tready drops only when the input register holds an item the
// queue has no room for, so a stalled out_ side stops input after a few items
module tlv_hex_tag_parser_unit #(
  parameter int unsigned MAX_LEN     = tlvhp_pkg::MAX_LEN_DEF,
  parameter int unsigned OFFSET_BITS = tlvhp_pkg::OFFSET_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [tlvhp_pkg::IN_DATA_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] tag_value, [16] ctor_flag, [17] space_form, [33:18] value_len,
  // [57:34] tag_offset, [65:58] value_byte, [66] value_last, [67] error_code, rest 0
  output logic [tlvhp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [1:0]                           out_tuser,  // [1:0] kind
  output logic                                 out_tlast,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tlvhp_pkg::CFG_AW-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import tlvhp_pkg::*;

  logic            inv_r, inv_nxt;
  logic [7:0]      byte_r;
  logic            eom_r;
  logic            mask_r;
  logic            fire, room, in_acc;
  rec_t            rec0, rec1, out_rec;
  logic [1:0]      rec_cnt;
  logic [1:0]      push_cnt;

  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_MASK_CTOR) ? {31'd0, mask_r} : 32'd0;
  assign fire      = inv_r && room;
  assign in_tready = !inv_r || fire;
  assign in_acc    = in_tvalid && in_tready;
  assign inv_nxt   = in_acc || (inv_r && !fire);
  assign push_cnt  = fire ? rec_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r  <= 1'b0;
      mask_r <= 1'b0;
    end else begin
      inv_r <= inv_nxt;
      if (psel && penable && pwrite && pready && paddr[2] == REG_MASK_CTOR) begin
        mask_r <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_tdata;
      eom_r  <= in_tlast;
    end
  end

  tlvhp_parse #(
    .MAX_LEN     (MAX_LEN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .data_byte (byte_r),
    .eom       (eom_r),
    .mask_ctor (mask_r),
    .rec0      (rec0),
    .rec1      (rec1),
    .rec_cnt   (rec_cnt)
  );

  tlvhp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .rec0      (rec0),
    .rec1      (rec1),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (out_rec)
  );

  assign out_tuser = out_rec.kind;
  assign out_tlast = out_rec.run_last;
  assign out_tdata = {4'h0, out_rec.error_code, out_rec.value_last, out_rec.value_byte,
                      out_rec.tag_offset, out_rec.value_len, out_rec.space_form,
                      out_rec.ctor_flag, out_rec.tag_value};

endmodule

FILE: sim/tlv_record_checker.sv
// record checker for the tlv hex tag parser: predicts the records of every accepted item
// and compares each out_ record field by field; depends on tlvhp_pkg
`timescale 1ns / 1ps

module tlv_record_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [tlvhp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [tlvhp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [1:0]                       out_tuser,
  input  logic                             out_tlast,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tlvhp_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                      pwdata,
  input  logic [31:0]                      prdata,
  input  logic                             pready,
  output int unsigned                      mismatches,
  output int unsigned                      open_recs
);
  import tlvhp_pkg::*;

  typedef enum logic [2:0] {
    P_TAG,
    P_LEN0,
    P_DIGITS,
    P_VALUE,
    P_DROP
  } parse_phase_t;

  parse_phase_t phase;
  logic [1:0]   hex_cnt;
  logic [15:0]  tag_acc;
  int unsigned  len_acc;
  logic         len_neg;
  logic         len_dig;
  logic         len_ovf;
  logic [15:0]  remaining;
  logic [23:0]  byte_off;
  logic [23:0]  tag_start;
  logic         mask_ctor;

  rec_t        step_recs[2];
  int          step_n;
  rec_t        pending_recs[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40) begin
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  task automatic clear_parse();
    phase     = P_TAG;
    hex_cnt   = '0;
    tag_acc   = '0;
    len_acc   = 0;
    len_neg   = 1'b0;
    len_dig   = 1'b0;
    len_ovf   = 1'b0;
    remaining = '0;
  endtask

  task automatic push_rec(input logic [1:0] k, input logic [7:0] vbyte, input logic vlast,
                          input logic code);
    rec_t r;
    r = '0;
    r.kind       = k;
    r.value_byte = vbyte;
    r.value_last = vlast;
    r.error_code = code;
    step_recs[step_n] = r;
    step_n++;
  endtask

  task automatic emit_header(input logic var_form);
    rec_t r;
    r = '0;
    r.kind         = KIND_HDR;
    r.tag_value    = mask_ctor ? (tag_acc & 16'h7fff) : tag_acc;
    r.ctor_flag    = tag_acc[15];
    r.space_form   = var_form;
    r.value_len    = var_form ? 16'd0 : len_acc[15:0];
    r.tag_offset   = tag_start;
    step_recs[step_n] = r;
    step_n++;
  endtask

  task automatic emit_error(input logic code);
    push_rec(KIND_ERR, 8'h00, 1'b0, code);
    phase = P_DROP;
  endtask

  task automatic add_digit(input int unsigned d);
    int unsigned v;
    len_dig = 1'b1;
    if (!len_ovf) begin
      v = len_acc * 10 + d;
      if (v > MAX_LEN_DEF) len_ovf = 1'b1;
      else len_acc = v;
    end
  endtask

  task automatic len_cut_short();
    if (!len_dig || (!len_neg && len_ovf)) emit_error(ERR_LEN);
    else emit_error(ERR_SHORT);
  endtask

  task automatic len_separator(input logic eom);
    if (!len_dig || (!len_neg && len_ovf)) begin
      emit_error(ERR_LEN);
    end else if (len_neg && (len_acc != 0 || len_ovf)) begin
      emit_error(ERR_SHORT);
    end else if (len_acc == 0) begin
      emit_header(1'b0);
      if (eom) push_rec(KIND_END, 8'h00, 1'b0, 1'b0);
      clear_parse();
    end else if (eom) begin
      emit_error(ERR_SHORT);
    end else begin
      emit_header(1'b0);
      remaining = len_acc[15:0];
      phase     = P_VALUE;
    end
  endtask

  task automatic digit_or_sep(input logic [7:0] b, input logic eom);
    if (b >= CH_ZERO && b <= CH_NINE) begin
      add_digit(b - CH_ZERO);
      if (eom) len_cut_short();
    end else begin
      len_separator(eom);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eom);
    logic [23:0] pos;
    logic [15:0] d;
    pos      = byte_off;
    byte_off = byte_off + 24'd1;
    step_n   = 0;
    case (phase)
      P_TAG: begin
        d = (b > CH_NINE) ? ({8'h00, b} - 16'h0037) : ({8'h00, b} - 16'h0030);
        if (hex_cnt == 2'd0) tag_start = pos;
        tag_acc = (tag_acc << 4) + d;
        if (hex_cnt == 2'd3) begin
          hex_cnt = 2'd0;
          phase   = P_LEN0;
        end else begin
          hex_cnt = hex_cnt + 2'd1;
        end
        if (eom) emit_error(ERR_SHORT);
      end
      P_LEN0: begin
        if (b == CH_SPACE) begin
          emit_header(1'b1);
          if (eom) push_rec(KIND_END, 8'h00, 1'b0, 1'b0);
          clear_parse();
        end else begin
          phase = P_DIGITS;
          if (b == CH_MINUS) begin
            len_neg = 1'b1;
            if (eom) len_cut_short();
          end else begin
            digit_or_sep(b, eom);
          end
        end
      end
      P_DIGITS: digit_or_sep(b, eom);
      P_VALUE: begin
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) begin
          push_rec(KIND_VAL, b, 1'b1, 1'b0);
          if (eom) push_rec(KIND_END, 8'h00, 1'b0, 1'b0);
          clear_parse();
        end else if (eom) begin
          emit_error(ERR_SHORT);
        end else begin
          push_rec(KIND_VAL, b, 1'b0, 1'b0);
        end
      end
      default: ;
    endcase
    if (eom) begin
      clear_parse();
      byte_off  = '0;
      tag_start = '0;
    end
    if (step_n > 0) step_recs[step_n-1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) pending_recs.insert(pending_recs.size(), step_recs[i]);
  endtask

  task automatic check_record(input rec_t want);
    if (out_tuser != want.kind) report_mismatch("kind", out_tuser, want.kind);
    if (out_tdata[15:0] != want.tag_value)
      report_mismatch("tag_value", out_tdata[15:0], want.tag_value);
    if (out_tdata[16] != want.ctor_flag)
      report_mismatch("ctor_flag", out_tdata[16], want.ctor_flag);
    if (out_tdata[17] != want.space_form)
      report_mismatch("space_form", out_tdata[17], want.space_form);
    if (out_tdata[33:18] != want.value_len)
      report_mismatch("value_len", out_tdata[33:18], want.value_len);
    if (out_tdata[57:34] != want.tag_offset)
      report_mismatch("tag_offset", out_tdata[57:34], want.tag_offset);
    if (out_tdata[65:58] != want.value_byte)
      report_mismatch("value_byte", out_tdata[65:58], want.value_byte);
    if (out_tdata[66] != want.value_last)
      report_mismatch("value_last", out_tdata[66], want.value_last);
    if (out_tdata[67] != want.error_code)
      report_mismatch("error_code", out_tdata[67], want.error_code);
    if (out_tdata[OUT_DATA_W-1:68] != '0)
      report_mismatch("tdata padding", out_tdata[OUT_DATA_W-1:68], 0);
    if (out_tlast != want.run_last) report_mismatch("run_last", out_tlast, want.run_last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      byte_off  = '0;
      tag_start = '0;
      mask_ctor = 1'b0;
      pending_recs.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[CFG_AW-1:2] == REG_MASK_CTOR) mask_ctor = pwdata[0];
        end else if (prdata != {31'd0, mask_ctor}) begin
          report_mismatch("mask_ctor readback", prdata, {31'd0, mask_ctor});
        end
      end
      if (out_tvalid && out_tready) begin
        if (pending_recs.size() == 0) report_mismatch("record with none pending",
                                                      out_tdata[31:0], 0);
        else check_record(pending_recs.pop_front());
      end
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
    end
    open_recs = pending_recs.size();
  end

endmodule

FILE: sim/tb_tlv_hex_tag_parser_unit.sv
// testbench top for tlv_hex_tag_parser_unit: builds tlv messages, drives the in_ stream
// and apb port, stalls out_; tlv_record_checker does the checking; depends on tlvhp_pkg
`timescale 1ns / 1ps

module tb_tlv_hex_tag_parser_unit;
  import tlvhp_pkg::*;

  localparam logic [CFG_AW-1:0] MASK_ADDR   = {REG_MASK_CTOR, 2'b00};
  localparam int unsigned       IDLE_LIMIT  = 1000;
  localparam int unsigned       SETTLE_CYC  = 8;
  localparam int unsigned       PHASE_ITEMS = 190;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_AW-1:0]     paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int unsigned mismatches;
  int unsigned open_recs;

  logic        idle_on;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned kind_seen[4];
  int unsigned bytes_sent;
  int unsigned msgs_sent;
  int unsigned counted;
  int unsigned junk_n;
  logic [7:0]  msg[$];

  tlv_hex_tag_parser_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tlv_record_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .mismatches(mismatches),
    .open_recs (open_recs)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // out_ stalls in random bursts while idle_on is set, always with a ready cycle in between
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (idle_on && out_tready && $urandom_range(0, 4) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) kind_seen[out_tuser]++;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (psel && penable && pready)
        || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item accepted for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = MASK_ADDR;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (open_recs != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_mask(input logic m);
    wait_idle();
    apb_access(1'b1, {31'd0, m});
    apb_access(1'b0, 32'd0);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eom);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = eom;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    bytes_sent += msg.size();
    counted    += msg.size() - junk_n;
    msgs_sent++;
    msg.delete();
    junk_n = 0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    msg.insert(msg.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_junk(input int unsigned n);
    add_random(n);
    junk_n += n;
  endtask

  task automatic add_tag();
    int unsigned k;
    repeat (4) begin
      k = $urandom_range(0, 19);
      if (k < 10) add_byte(8'(CH_ZERO + k));
      else if (k < 16) add_byte(8'(8'h41 + k - 10));
      else if (k < 19) add_byte(8'(8'h61 + $urandom_range(0, 5)));
      else add_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_separator();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b >= CH_ZERO && b <= CH_NINE);
    add_byte(b);
  endtask

  task automatic add_len_tag(input string digits, input int unsigned nbytes);
    add_tag();
    add_text(digits);
    add_separator();
    add_random(nbytes);
  endtask

  task automatic build_good();
    int unsigned ntags;
    int unsigned len;
    string       digits;
    ntags = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
    repeat (ntags) begin
      if ($urandom_range(0, 3) == 0) begin
        add_tag();
        add_byte(CH_SPACE);
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: len = $urandom_range(0, 4);
          19:      len = $urandom_range(17, 40);
          default: len = $urandom_range(5, 16);
        endcase
        digits = $sformatf("%0d", len);
        if ($urandom_range(0, 7) == 0) digits = {"0", digits};
        if (len == 0 && $urandom_range(0, 2) == 0) digits = "-0";
        add_len_tag(digits, len);
      end
    end
  endtask

  task automatic build_broken();
    int unsigned cut;
    case ($urandom_range(0, 6))
      0: begin
        build_good();
        cut = $urandom_range(1, msg.size());
        while (msg.size() > cut) void'(msg.pop_back());
      end
      1: begin
        add_len_tag($sformatf("-%0d", $urandom_range(1, 999)), 0);
        add_junk($urandom_range(0, 4));
      end
      2: begin
        add_tag();
        case ($urandom_range(0, 2))
          0: add_text("-");
          1: add_text("+");
          default: add_byte(8'(8'h41 + $urandom_range(0, 25)));
        endcase
        add_junk($urandom_range(0, 4));
      end
      3: begin
        case ($urandom_range(0, 3))
          0: add_len_tag("65536", 0);
          1: add_len_tag("99999", 0);
          2: add_len_tag("1234567", 0);
          default: add_len_tag("-99999", 0);
        endcase
        add_junk($urandom_range(0, 4));
      end
      4: begin
        if ($urandom_range(0, 1) == 0) add_len_tag("65535", $urandom_range(0, 5));
        else add_len_tag($sformatf("%0d", $urandom_range(41, 65535)), $urandom_range(0, 5));
      end
      5: add_random($urandom_range(1, 8));
      default: begin
        add_tag();
        case ($urandom_range(0, 6))
          0: add_text("-");
          1: add_text($sformatf("%0d", $urandom_range(1, 65535)));
          2: add_text("65536");
          3: add_text("99999999");
          4: add_text($sformatf("-%0d", $urandom_range(1, 99)));
          5: add_text("-0");
          default: ;
        endcase
      end
    endcase
  endtask

  task automatic run_random(input logic m, input logic allow_idle);
    set_mask(m);
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      if ($urandom_range(0, 3) != 0) build_good();
      else build_broken();
      idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      send_msg();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_on      = 1'b1;
    bytes_sent   = 0;
    msgs_sent    = 0;
    counted      = 0;
    junk_n       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: space form with constructor bit, end inside tag, values at both extremes,
    // negative length, length without digits
    set_mask(1'b0);
    add_text("FFFF ");
    send_msg();
    add_text("g~");
    send_msg();
    add_text("00002:");
    add_byte(8'h00);
    add_byte(8'hff);
    send_msg();
    add_text("7fff-3x");
    send_msg();
    add_text("1234+");
    send_msg();

    run_random(1'b1, 1'b1);
    run_random(1'b0, 1'b1);
    run_random(1'b1, 1'b1);
    run_random(1'b0, 1'b0);

    wait_idle();
    $display("sent %0d bytes in %0d messages, mask_ctor at 0 and 1, with and without stalls",
             bytes_sent, msgs_sent);
    $display("records: %0d headers, %0d value bytes, %0d end ok, %0d errors",
             kind_seen[KIND_HDR], kind_seen[KIND_VAL], kind_seen[KIND_END], kind_seen[KIND_ERR]);
    if (mismatches == 0 && open_recs == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
